// File: rtl/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the beep pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned TimeBitsDef = 24;
  localparam int unsigned FieldTimeW  = 24;
  localparam int unsigned RepeatW     = 16;
  localparam int unsigned CfgW        = 16;
  localparam int unsigned CompareW    = 15;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [CfgW-1:0] TickStepRst   = 16'd10;
  localparam logic [CfgW-1:0] TonePeriodRst = 16'd500;

  // register index, taken from paddr[2]
  localparam logic RegTickStep   = 1'b0;
  localparam logic RegTonePeriod = 1'b1;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_ON   = 2'd1,
    FN_OFF  = 2'd2,
    FN_LOAD = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SOUND  = 2'd1,
    PH_PERIOD = 2'd2,
    PH_IDLE   = 2'd3
  } phase_e;

  typedef struct packed {
    func_e                 func;
    logic [FieldTimeW-1:0] on_time;
    logic [FieldTimeW-1:0] off_time;
    logic [RepeatW-1:0]    repeat_count;
  } item_t;

  typedef struct packed {
    logic [CfgW-1:0] tick_step;
    logic [CfgW-1:0] tone_period;
  } cfg_t;

  typedef struct packed {
    logic [CompareW-1:0] pwm_compare;
    phase_e              phase;
  } result_t;

endpackage

// File: rtl/bps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_cfg
// APB register file holding tick step and tone period.
// ----------------------------------------------------------------------------
module bps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bps_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bps_pkg::ApbDataW-1:0]  pwdata,
  output logic [bps_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output bps_pkg::cfg_t                 cfg_o
);

  logic [bps_pkg::CfgW-1:0] tick_step_q, tick_step_d;
  logic [bps_pkg::CfgW-1:0] tone_period_q, tone_period_d;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    tick_step_d   = tick_step_q;
    tone_period_d = tone_period_q;
    if (wr_en) begin
      if (paddr[2] == bps_pkg::RegTickStep) begin
        tick_step_d = pwdata[bps_pkg::CfgW-1:0];
      end else begin
        tone_period_d = pwdata[bps_pkg::CfgW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q   <= bps_pkg::TickStepRst;
      tone_period_q <= bps_pkg::TonePeriodRst;
    end else begin
      tick_step_q   <= tick_step_d;
      tone_period_q <= tone_period_d;
    end
  end

  always_comb begin
    if (paddr[2] == bps_pkg::RegTickStep) begin
      prdata = bps_pkg::ApbDataW'(tick_step_q);
    end else begin
      prdata = bps_pkg::ApbDataW'(tone_period_q);
    end
  end

  assign cfg_o.tick_step   = tick_step_q;
  assign cfg_o.tone_period = tone_period_q;

endmodule

// File: rtl/bps_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_in_stage
// Input register: captures one item beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bps_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bps_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           take_i,
  output bps_pkg::item_t item_o
);

  logic           vld_q, vld_d;
  bps_pkg::item_t item_q, item_d;

  // free when empty or when the held beat leaves this cycle
  assign ready_o = !vld_q || take_i;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (ready_o) begin
      vld_d = valid_i;
      if (valid_i) begin
        item_d = item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

// File: rtl/bps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_core
// Beep sequencer state, one step per item, and the result register.
// ----------------------------------------------------------------------------
module bps_core #(
  parameter int unsigned TIME_BITS = bps_pkg::TimeBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bps_pkg::cfg_t    cfg_i,
  input  logic             valid_i,
  input  bps_pkg::item_t   item_i,
  output logic             take_o,
  output logic             valid_o,
  input  logic             ready_i,
  output bps_pkg::result_t result_o
);

  localparam int unsigned EW = TIME_BITS + 2;
  localparam int unsigned SW = EW + bps_pkg::CfgW + 1;
  localparam int unsigned XW = TIME_BITS + bps_pkg::FieldTimeW;

  bps_pkg::phase_e                 phase_q, phase_d;
  logic [TIME_BITS-1:0]            on_len_q, on_len_d;
  logic [TIME_BITS-1:0]            off_len_q, off_len_d;
  logic [bps_pkg::RepeatW-1:0]     beeps_q, beeps_d;
  logic [EW-1:0]                   elapsed_q, elapsed_d;
  logic [bps_pkg::CompareW-1:0]    compare_q, compare_d;
  logic                            out_vld_q, out_vld_d;
  bps_pkg::result_t                res_q, res_d;

  logic [SW-1:0]                   sum;
  logic [EW-1:0]                   adv;
  logic [EW-1:0]                   whole;
  logic [EW-1:0]                   on_e;
  logic [XW-1:0]                   on_x, off_x;
  logic [bps_pkg::CompareW-1:0]    snd;

  assign take_o = valid_i && (!out_vld_q || ready_i);

  assign sum   = SW'(elapsed_q) + SW'(cfg_i.tick_step);
  assign adv   = sum[EW-1:0];
  assign on_e  = EW'(on_len_q);
  assign whole = EW'(on_len_q) + EW'(off_len_q);
  assign on_x  = XW'(item_i.on_time);
  assign off_x = XW'(item_i.off_time);
  assign snd   = cfg_i.tone_period[bps_pkg::CfgW-1:1];

  always_comb begin
    phase_d   = phase_q;
    on_len_d  = on_len_q;
    off_len_d = off_len_q;
    beeps_d   = beeps_q;
    elapsed_d = elapsed_q;
    compare_d = compare_q;
    if (take_o) begin
      case (item_i.func)
        bps_pkg::FN_TICK: begin
          case (phase_q)
            bps_pkg::PH_START: begin
              if (on_len_q != '0) begin
                compare_d = snd;
                if (off_len_q != '0) begin
                  elapsed_d = '0;
                  phase_d   = bps_pkg::PH_SOUND;
                end else begin
                  phase_d = bps_pkg::PH_IDLE;
                end
              end else begin
                compare_d = '0;
                phase_d   = bps_pkg::PH_IDLE;
              end
            end
            bps_pkg::PH_SOUND: begin
              elapsed_d = adv;
              if (adv >= on_e) begin
                compare_d = '0;
                phase_d   = bps_pkg::PH_PERIOD;
              end
            end
            bps_pkg::PH_PERIOD: begin
              elapsed_d = adv;
              if (adv >= whole) begin
                // carry the remainder into the next beep
                elapsed_d = adv - whole;
                if (beeps_q == bps_pkg::RepeatW'(1)) begin
                  compare_d = '0;
                  phase_d   = bps_pkg::PH_IDLE;
                end else begin
                  compare_d = snd;
                  if (beeps_q != '0) begin
                    beeps_d = beeps_q - bps_pkg::RepeatW'(1);
                  end
                  phase_d = bps_pkg::PH_SOUND;
                end
              end
            end
            default: begin
              // idle: hold everything
            end
          endcase
        end
        bps_pkg::FN_ON: begin
          on_len_d  = TIME_BITS'(1);
          off_len_d = '0;
          beeps_d   = '0;
          phase_d   = bps_pkg::PH_START;
        end
        bps_pkg::FN_OFF: begin
          on_len_d  = '0;
          off_len_d = '0;
          beeps_d   = '0;
          phase_d   = bps_pkg::PH_START;
        end
        default: begin
          on_len_d  = on_x[TIME_BITS-1:0];
          off_len_d = off_x[TIME_BITS-1:0];
          beeps_d   = item_i.repeat_count;
          phase_d   = bps_pkg::PH_START;
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (take_o) begin
      out_vld_d         = 1'b1;
      res_d.pwm_compare = compare_d;
      res_d.phase       = phase_d;
    end else if (ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bps_pkg::PH_START;
      on_len_q  <= '0;
      off_len_q <= '0;
      beeps_q   <= '0;
      elapsed_q <= '0;
      compare_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      on_len_q  <= on_len_d;
      off_len_q <= off_len_d;
      beeps_q   <= beeps_d;
      elapsed_q <= elapsed_d;
      compare_q <= compare_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = out_vld_q;
  assign result_o = res_q;

endmodule

// File: rtl/beep_pattern_sequencer.sv
`timescale 1ns / 1ps
// A result beat passes the input register, then the result register in the core.
// Throughput: one item per cycle while m_axis_tready holds; the input register
// and result register let a new beat in while a result waits on the master side.
// Each step is one add and compare on the elapsed counter in the core.
// Reset (rst_ni low, asynchronous) clears the sequencer to start pending with
// zero lengths and compare, tick step 10 and tone period 500.
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// Top level: stream ports, APB registers and the beep sequencer core.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer #(
  parameter int unsigned TIME_BITS = bps_pkg::TimeBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bps_pkg::ApbAddrW-1:0] paddr,
  input  logic [bps_pkg::ApbDataW-1:0] pwdata,
  output logic [bps_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [23:0] on_time, [47:24] off_time, [63:48] repeat_count
  input  logic [63:0]                  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [14:0] pwm_compare, [16:15] phase, [23:17] zero
  output logic [23:0]                  m_axis_tdata
);

  bps_pkg::cfg_t    cfg;
  bps_pkg::item_t   in_item;
  bps_pkg::item_t   held_item;
  bps_pkg::result_t result;
  logic             held_vld;
  logic             take;

  assign in_item.func         = bps_pkg::func_e'(s_axis_tuser);
  assign in_item.on_time      = s_axis_tdata[23:0];
  assign in_item.off_time     = s_axis_tdata[47:24];
  assign in_item.repeat_count = s_axis_tdata[63:48];

  bps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bps_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (held_vld),
    .take_i  (take),
    .item_o  (held_item)
  );

  bps_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (held_vld),
    .item_i   (held_item),
    .take_o   (take),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result)
  );

  assign m_axis_tdata = {7'd0, result.phase, result.pwm_compare};

endmodule

// File: rtl/bps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks for the beep pattern sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // beats inside the block: at most the input and the result register
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result beat without an accepted item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more beats in flight than registers hold");

  a_silent_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16:15] == bps_pkg::PH_PERIOD
      |-> m_axis_tdata[14:0] == 15'd0)
    else $error("tone sounding while waiting for period end");

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: test/tb_beep_pattern_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_beep_pattern_sequencer
// Drives tick and pattern command beats into the sequencer, runs its own
// model of the beep state machine alongside, and compares every result beat
// field by field. APB writes move the tick step and tone period through
// their extremes, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_beep_pattern_sequencer;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [bps_pkg::ApbAddrW-1:0] paddr         = '0;
  logic [bps_pkg::ApbDataW-1:0] pwdata        = '0;
  logic [bps_pkg::ApbDataW-1:0] prdata;
  logic                         pready;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // [23:0] on_time, [47:24] off_time, [63:48] repeat_count
  logic [63:0]                  s_axis_tdata  = '0;
  // [1:0] func
  logic [1:0]                   s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // [14:0] pwm_compare, [16:15] phase, [23:17] zero
  logic [23:0]                  m_axis_tdata;

  beep_pattern_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // model of the sequencer state and its registers
  logic [bps_pkg::CfgW-1:0]       cfg_tick_step   = bps_pkg::TickStepRst;
  logic [bps_pkg::CfgW-1:0]       cfg_tone_period = bps_pkg::TonePeriodRst;
  bps_pkg::phase_e                seq_phase       = bps_pkg::PH_START;
  logic [bps_pkg::FieldTimeW-1:0] seq_on          = '0;
  logic [bps_pkg::FieldTimeW-1:0] seq_off         = '0;
  logic [bps_pkg::RepeatW-1:0]    seq_beeps       = '0;
  logic [bps_pkg::FieldTimeW+1:0] seq_elapsed     = '0;
  logic [bps_pkg::CompareW-1:0]   seq_compare     = '0;

  bps_pkg::result_t expected_outputs[$];
  int unsigned      beats_sent   = 0;
  int unsigned      n_fail       = 0;
  int unsigned      stall_cycles = 0;
  bit               quiet        = 1'b0;

  function automatic void sequence_step(input bps_pkg::func_e fn,
                                        input logic [bps_pkg::FieldTimeW-1:0] on_t,
                                        input logic [bps_pkg::FieldTimeW-1:0] off_t,
                                        input logic [bps_pkg::RepeatW-1:0] rep);
    logic [bps_pkg::CompareW-1:0]   half_tone;
    logic [bps_pkg::FieldTimeW+1:0] whole;
    half_tone = bps_pkg::CompareW'(cfg_tone_period >> 1);
    whole     = (bps_pkg::FieldTimeW+2)'(seq_on) + (bps_pkg::FieldTimeW+2)'(seq_off);
    case (fn)
      bps_pkg::FN_TICK: begin
        case (seq_phase)
          bps_pkg::PH_START: begin
            if (seq_on != 0) begin
              seq_compare = half_tone;
              if (seq_off != 0) begin
                seq_elapsed = '0;
                seq_phase   = bps_pkg::PH_SOUND;
              end else begin
                seq_phase = bps_pkg::PH_IDLE;
              end
            end else begin
              seq_compare = '0;
              seq_phase   = bps_pkg::PH_IDLE;
            end
          end
          bps_pkg::PH_SOUND: begin
            seq_elapsed = seq_elapsed + (bps_pkg::FieldTimeW+2)'(cfg_tick_step);
            if (seq_elapsed >= (bps_pkg::FieldTimeW+2)'(seq_on)) begin
              seq_compare = '0;
              seq_phase   = bps_pkg::PH_PERIOD;
            end
          end
          bps_pkg::PH_PERIOD: begin
            seq_elapsed = seq_elapsed + (bps_pkg::FieldTimeW+2)'(cfg_tick_step);
            // carry the remainder into the next beep
            if (seq_elapsed >= whole) begin
              seq_elapsed = seq_elapsed - whole;
              if (seq_beeps == 1) begin
                seq_compare = '0;
                seq_phase   = bps_pkg::PH_IDLE;
              end else begin
                seq_compare = half_tone;
                if (seq_beeps != 0) seq_beeps = seq_beeps - 1'b1;
                seq_phase = bps_pkg::PH_SOUND;
              end
            end
          end
          default: ;
        endcase
      end
      bps_pkg::FN_ON: begin
        seq_on    = bps_pkg::FieldTimeW'(1);
        seq_off   = '0;
        seq_beeps = '0;
        seq_phase = bps_pkg::PH_START;
      end
      bps_pkg::FN_OFF: begin
        seq_on    = '0;
        seq_off   = '0;
        seq_beeps = '0;
        seq_phase = bps_pkg::PH_START;
      end
      default: begin
        seq_on    = on_t;
        seq_off   = off_t;
        seq_beeps = rep;
        seq_phase = bps_pkg::PH_START;
      end
    endcase
    expected_outputs.push_back('{pwm_compare: seq_compare, phase: seq_phase});
  endfunction

  // offer one beat, with random gaps before it, and predict on acceptance
  task automatic send_beat(input bps_pkg::func_e fn,
                           input logic [bps_pkg::FieldTimeW-1:0] on_t,
                           input logic [bps_pkg::FieldTimeW-1:0] off_t,
                           input logic [bps_pkg::RepeatW-1:0] rep);
    while (!quiet && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {rep, off_t, on_t};
    do @(posedge clk_i); while (!s_axis_tready);
    sequence_step(fn, on_t, off_t, rep);
    beats_sent++;
  endtask

  // unused fields carry noise
  task automatic send_tick();
    send_beat(bps_pkg::FN_TICK, bps_pkg::FieldTimeW'($urandom),
              bps_pkg::FieldTimeW'($urandom), bps_pkg::RepeatW'($urandom));
  endtask

  task automatic send_load(input int unsigned on_t, input int unsigned off_t,
                           input int unsigned rep);
    send_beat(bps_pkg::FN_LOAD, bps_pkg::FieldTimeW'(on_t), bps_pkg::FieldTimeW'(off_t),
              bps_pkg::RepeatW'(rep));
  endtask

  // drop valid and hold until every result is back, plus the pipeline latency
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [bps_pkg::CfgW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bps_pkg::ApbAddrW'({idx, 2'b00});
    pwdata  <= bps_pkg::ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bps_pkg::RegTonePeriod) cfg_tone_period = value;
    else cfg_tick_step = value;
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    bps_pkg::result_t             want;
    logic [bps_pkg::CompareW-1:0] got_compare;
    bps_pkg::phase_e              got_phase;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_compare = m_axis_tdata[bps_pkg::CompareW-1:0];
      got_phase   = bps_pkg::phase_e'(m_axis_tdata[bps_pkg::CompareW+1:bps_pkg::CompareW]);
      if (expected_outputs.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result beat: compare %0d phase %0d", got_compare, got_phase);
      end else begin
        want = expected_outputs.pop_front();
        if (got_compare !== want.pwm_compare || got_phase !== want.phase) begin
          n_fail++;
          if (n_fail <= 10)
            $display("result mismatch: expected compare %0d phase %0d, got compare %0d phase %0d",
                     want.pwm_compare, want.phase, got_compare, got_phase);
        end
      end
    end
  end

  // result receiver: random stalls, or a counted hold-off when asked
  always @(posedge clk_i) begin
    if (stall_cycles > 0) begin
      m_axis_tready <= 1'b0;
      stall_cycles  <= stall_cycles - 1;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 19);
    end
  end

  task automatic test_directed();
    send_tick();                               // start with nothing loaded
    send_tick();                               // idle tick
    send_beat(bps_pkg::FN_ON, '1, '0, '1);
    send_tick();
    send_tick();
    send_beat(bps_pkg::FN_OFF, '0, '1, '0);
    send_tick();
    send_load(0, 7, 3);                        // zero on-time
    send_tick();
    send_load(5, 0, 2);                        // zero off-time gives a steady tone
    send_tick();
    send_load(20, 15, 2);                      // two beeps with a carried remainder
    repeat (8) send_tick();
    send_load(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_tick();
    send_tick();
    send_beat(bps_pkg::FN_ON, '0, '0, '0);     // command leaves compare alone
    send_tick();
  endtask

  task automatic test_register_extremes();
    drain_results();
    write_register(bps_pkg::RegTickStep, '0);
    write_register(bps_pkg::RegTonePeriod, '0);
    send_load(5, 5, 0);
    repeat (3) send_tick();                    // counter must not move
    drain_results();
    write_register(bps_pkg::RegTickStep, 16'hFFFF);
    write_register(bps_pkg::RegTonePeriod, 16'hFFFF);
    send_load(100000, 100000, 2);
    repeat (9) send_tick();
    drain_results();
    write_register(bps_pkg::RegTickStep, 16'd1);
    write_register(bps_pkg::RegTonePeriod, 16'd1);
    send_beat(bps_pkg::FN_ON, '0, '0, '0);
    send_tick();
    drain_results();
    write_register(bps_pkg::RegTonePeriod, 16'd2);
    send_load(2, 1, 0);
    repeat (6) send_tick();
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    stall_cycles <= 60;
    send_load(30, 20, 0);
    repeat (23) send_tick();
    quiet = 1'b0;
  endtask

  task automatic test_random(input logic [bps_pkg::CfgW-1:0] step,
                             input logic [bps_pkg::CfgW-1:0] tone,
                             input int unsigned n_items);
    int unsigned stop_at;
    int unsigned unit;
    int unsigned on_t;
    int unsigned off_t;
    int unsigned rep;
    int unsigned pick;
    drain_results();
    write_register(bps_pkg::RegTickStep, step);
    write_register(bps_pkg::RegTonePeriod, tone);
    unit    = step;
    stop_at = beats_sent + n_items;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise: any function, any field contents
        send_beat(bps_pkg::func_e'($urandom_range(3)), bps_pkg::FieldTimeW'($urandom),
                  bps_pkg::FieldTimeW'($urandom), bps_pkg::RepeatW'($urandom));
      end else if (pick < 18) begin
        send_beat($urandom_range(1) ? bps_pkg::FN_ON : bps_pkg::FN_OFF,
                  bps_pkg::FieldTimeW'($urandom), bps_pkg::FieldTimeW'($urandom),
                  bps_pkg::RepeatW'($urandom));
        repeat ($urandom_range(1, 4)) send_tick();
      end else begin
        // pattern lengths sized in units of the tick step
        on_t  = $urandom_range(0, 4) * unit + $urandom_range(0, unit);
        off_t = $urandom_range(0, 4) * unit + $urandom_range(0, unit);
        rep   = $urandom_range(0, 3);
        if ($urandom_range(9) == 0) on_t = 0;
        if ($urandom_range(9) == 0) off_t = 0;
        if ($urandom_range(9) == 0) rep = $urandom;
        if ($urandom_range(9) == 0) begin
          on_t  = $urandom;
          off_t = $urandom;
        end
        send_load(on_t, off_t, rep);
        repeat ($urandom_range(1, 40)) send_tick();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(bps_pkg::TickStepRst, bps_pkg::TonePeriodRst, 160);
    quiet = 1'b1;                              // long stretch without idling
    test_random(16'd1, 16'hFFFF, 160);
    quiet = 1'b0;
    test_random(16'hFFFF, 16'd1, 160);
    test_random(bps_pkg::CfgW'($urandom_range(1, 65535)), bps_pkg::CfgW'($urandom), 160);
    drain_results();
    repeat (4) @(posedge clk_i);
    if (n_fail == 0 && expected_outputs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/bps_pkg.sv
rtl/bps_cfg.sv
rtl/bps_in_stage.sv
rtl/bps_core.sv
rtl/beep_pattern_sequencer.sv
rtl/bps_checker.sv
test/tb_beep_pattern_sequencer.sv
